[rtl/flfa_pkg.sv]
// Shared types and constants for the free list fit allocator.
package flfa_pkg;

	localparam int FREE_SLOTS  = 64;
	localparam int PIECE_SLOTS = 64;
	localparam int ADDR_BITS   = 20;
	localparam int OWNER_BITS  = 16;
	localparam int LEN_W       = ADDR_BITS + 1;
	localparam int FIDX_W      = $clog2(FREE_SLOTS);
	localparam int PIDX_W      = $clog2(PIECE_SLOTS);
	localparam int SCAN_LEN    = (FREE_SLOTS > PIECE_SLOTS) ? FREE_SLOTS : PIECE_SLOTS;
	localparam int CNT_W       = $clog2(SCAN_LEN + 1);

	localparam logic [LEN_W-1:0] MEM_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

	// Result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_MEMORY_SIZE = 2'd0;
	localparam logic [1:0] REG_FIT_MODE    = 2'd1;

	typedef enum logic [1:0] {
		FOP_NONE,
		FOP_REBUILD,
		FOP_CARVE,
		FOP_GIVE
	} fop_t;

	typedef struct packed {
		logic                 valid;
		logic [ADDR_BITS-1:0] start;
		logic [LEN_W-1:0]     len;
	} free_ent_t;

	// Running best-candidate token passed down the free cells
	typedef struct packed {
		logic                 found;
		logic [FIDX_W-1:0]    idx;
		logic [LEN_W-1:0]     diff;
		logic [ADDR_BITS-1:0] start;
	} tok_t;

	typedef struct packed {
		fop_t                 op;
		logic [LEN_W-1:0]     size;
		logic                 fit_first;
		logic [FIDX_W-1:0]    pick;
		logic                 remove;
		logic [ADDR_BITS-1:0] gstart;
		logic [LEN_W-1:0]     glen;
		logic [LEN_W-1:0]     gend;
		logic [LEN_W-1:0]     rb_len;
	} free_cmd_t;

	typedef struct packed {
		logic merge;
		logic insert;
	} give_ctl_t;

	typedef struct packed {
		logic                  valid;
		logic [OWNER_BITS-1:0] owner;
		logic [ADDR_BITS-1:0]  start;
		logic [LEN_W-1:0]      len;
	} piece_ent_t;

	typedef struct packed {
		logic              clear;
		logic              rotate;
		logic              wen;
		logic [PIDX_W-1:0] widx;
		piece_ent_t        wdata;
	} piece_cmd_t;

endpackage

[rtl/flfa_free_cell.sv]
// One free list entry with its stage of the fit search chain.
module flfa_free_cell import flfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [FIDX_W-1:0] idx,
	input  free_cmd_t         cmd,
	input  give_ctl_t         gctl,
	input  free_ent_t         left_ent,
	input  logic              left_g,
	input  free_ent_t         right_ent,
	input  tok_t              tok_in,
	output free_ent_t         ent,
	output logic              g,
	output logic              merge_hit,
	output tok_t              tok
);

	free_ent_t        ent_q, ent_d;
	tok_t             tok_q, tok_d;
	logic             at;
	logic             cand;
	logic [LEN_W-1:0] diff;

	assign ent = ent_q;
	assign tok = tok_q;

	// Insert position: first entry that is empty or starts at or after the returned end
	assign g         = !ent_q.valid || ({1'b0, ent_q.start} >= cmd.gend);
	assign at        = g && !left_g;
	assign merge_hit = at && ent_q.valid && ({1'b0, ent_q.start} == cmd.gend);

	// Fit search stage
	assign cand = ent_q.valid && (ent_q.len >= cmd.size);
	assign diff = ent_q.len - cmd.size;

	always_comb begin
		tok_d = tok_in;
		if (cand) begin
			if (cmd.fit_first) begin
				if (!tok_in.found) begin
					tok_d = '{found: 1'b1, idx: idx, diff: diff, start: ent_q.start};
				end
			end else if (!tok_in.found || diff <= tok_in.diff) begin
				tok_d = '{found: 1'b1, idx: idx, diff: diff, start: ent_q.start};
			end
		end
	end

	// Entry update
	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			FOP_REBUILD: begin
				if (idx == '0) begin
					ent_d = '{valid: (cmd.rb_len != '0), start: '0, len: cmd.rb_len};
				end else begin
					ent_d = '0;
				end
			end
			FOP_CARVE: begin
				if (idx == cmd.pick) begin
					if (cmd.remove) begin
						ent_d = right_ent;
					end else begin
						ent_d.start = ent_q.start + cmd.size[ADDR_BITS-1:0];
						ent_d.len   = ent_q.len - cmd.size;
					end
				end else if (idx > cmd.pick && cmd.remove) begin
					ent_d = right_ent;
				end
			end
			FOP_GIVE: begin
				if (gctl.merge) begin
					if (at) begin
						ent_d.start = cmd.gstart;
						ent_d.len   = ent_q.len + cmd.glen;
					end
				end else if (gctl.insert) begin
					if (at) begin
						ent_d = '{valid: 1'b1, start: cmd.gstart, len: cmd.glen};
					end else if (left_g) begin
						ent_d = left_ent;
					end
				end
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{valid: (idx == '0), start: '0, len: MEM_LIMIT};
			tok_q <= '0;
		end else begin
			ent_q <= ent_d;
			tok_q <= tok_d;
		end
	end

endmodule

[rtl/flfa_piece_cell.sv]
// One granted-piece entry of the rotating piece ring.
module flfa_piece_cell import flfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PIDX_W-1:0] idx,
	input  piece_cmd_t        cmd,
	input  piece_ent_t        right_ent,
	output piece_ent_t        ent
);

	logic                  valid_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [ADDR_BITS-1:0]  start_q;
	logic [LEN_W-1:0]      len_q;
	logic                  wr;

	assign wr  = cmd.wen && (idx == cmd.widx);
	assign ent = '{valid: valid_q, owner: owner_q, start: start_q, len: len_q};

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.rotate) begin
			valid_q <= right_ent.valid;
		end else if (wr) begin
			valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (cmd.rotate) begin
			owner_q <= right_ent.owner;
			start_q <= right_ent.start;
			len_q   <= right_ent.len;
		end else if (wr) begin
			owner_q <= cmd.wdata.owner;
			start_q <= cmd.wdata.start;
			len_q   <= cmd.wdata.len;
		end
	end

endmodule

[rtl/free_list_fit_allocator_core.sv]
// Free list fit allocator: control sequencer over a row of free cells and a piece ring.
// Items are taken one at a time: in_ready stays low from an item's transfer until its result is registered.
// The fit search walks one free cell per cycle and the piece ring rotates one entry per
// cycle, both over the full slot count.
// Reset: the free list is the single block [0, 2^20), the piece table is empty,
// fit_mode is best fit. A memory_size write rebuilds the list.
module free_list_fit_allocator_core import flfa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [15:0]           owner_id,
	input  logic [20:0]           request_size,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [19:0]           start_address,
	output logic [20:0]           owner_total,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [20:0]           cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_REL  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	localparam logic [CNT_W-1:0] SCAN_LAST  = CNT_W'(SCAN_LEN - 1);
	localparam logic [CNT_W-1:0] PIECE_CNT  = CNT_W'(PIECE_SLOTS);
	localparam logic [CNT_W-1:0] PIECE_LAST = CNT_W'(PIECE_SLOTS - 1);

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rel_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [LEN_W-1:0]      size_q;
	logic                  fit_mode_q;
	logic [LEN_W-1:0]      sum_q;
	logic                  slot_found_q;
	logic [PIDX_W-1:0]     slot_q;
	logic                  found_q;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [LEN_W-1:0]      total_q;

	free_ent_t             fe [FREE_SLOTS];
	logic                  fg [FREE_SLOTS];
	logic [FREE_SLOTS-1:0] fmerge;
	tok_t                  tk [FREE_SLOTS];
	piece_ent_t            pe [PIECE_SLOTS];

	free_cmd_t             fcmd;
	give_ctl_t             gctl;
	piece_cmd_t            pcmd;
	piece_ent_t            tail;
	tok_t                  tokf;

	logic in_fire, cfg_fire, done_fire, rebuild;
	logic head_hit, pick_ok, alloc_ok;
	logic [LEN_W-1:0] rb_len;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign rebuild   = cfg_fire && (cfg_index == REG_MEMORY_SIZE);
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign start_address = addr_q;
	assign owner_total   = total_q;

	assign tokf     = tk[FREE_SLOTS-1];
	assign pick_ok  = (size_q != '0) && tokf.found;
	assign alloc_ok = pick_ok && slot_found_q;
	assign head_hit = (state_q == S_REL) && pe[0].valid && (pe[0].owner == owner_q);
	assign rb_len   = (cfg_data > MEM_LIMIT) ? MEM_LIMIT : cfg_data;

	// Free cell command
	always_comb begin
		fcmd           = '0;
		fcmd.op        = FOP_NONE;
		fcmd.size      = size_q;
		fcmd.fit_first = fit_mode_q;
		fcmd.pick      = tokf.idx;
		fcmd.remove    = (tokf.diff == '0);
		fcmd.gstart    = pe[0].start;
		fcmd.glen      = pe[0].len;
		fcmd.gend      = {1'b0, pe[0].start} + pe[0].len;
		fcmd.rb_len    = rb_len;
		if (rebuild) begin
			fcmd.op = FOP_REBUILD;
		end else if (head_hit) begin
			fcmd.op = FOP_GIVE;
		end else if (done_fire && !rel_q && alloc_ok) begin
			fcmd.op = FOP_CARVE;
		end
	end

	assign gctl.merge  = |fmerge;
	assign gctl.insert = !fe[FREE_SLOTS-1].valid;

	// Piece ring command; a released head re-enters the tail as empty
	always_comb begin
		tail       = pe[0];
		tail.valid = pe[0].valid && !head_hit;
		pcmd.clear  = rebuild;
		pcmd.rotate = ((state_q == S_SCAN) && (cnt_q < PIECE_CNT)) || (state_q == S_REL);
		pcmd.wen    = done_fire && !rel_q && alloc_ok;
		pcmd.widx   = slot_q;
		pcmd.wdata  = '{valid: 1'b1, owner: owner_q, start: tokf.start, len: size_q};
	end

	// Row of free cells
	for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_free
		free_ent_t left_e, right_e;
		logic      left_gk;
		tok_t      tin;
		if (k == 0) begin : g_first
			assign left_e  = '0;
			assign left_gk = 1'b0;
			assign tin     = '0;
		end else begin : g_mid
			assign left_e  = fe[k-1];
			assign left_gk = fg[k-1];
			assign tin     = tk[k-1];
		end
		if (k == FREE_SLOTS - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = fe[k+1];
		end
		flfa_free_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (FIDX_W'(k)),
			.cmd       (fcmd),
			.gctl      (gctl),
			.left_ent  (left_e),
			.left_g    (left_gk),
			.right_ent (right_e),
			.tok_in    (tin),
			.ent       (fe[k]),
			.g         (fg[k]),
			.merge_hit (fmerge[k]),
			.tok       (tk[k])
		);
	end

	// Piece ring
	for (genvar k = 0; k < PIECE_SLOTS; k++) begin : g_piece
		piece_ent_t nxt;
		if (k == PIECE_SLOTS - 1) begin : g_tail
			assign nxt = tail;
		end else begin : g_body
			assign nxt = pe[k+1];
		end
		flfa_piece_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (PIDX_W'(k)),
			.cmd       (pcmd),
			.right_ent (nxt),
			.ent       (pe[k])
		);
	end

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b0;
		end else if (cfg_fire && cfg_index == REG_FIT_MODE) begin
			fit_mode_q <= cfg_data[0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			rel_q        <= 1'b0;
			slot_found_q <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q        <= '0;
						rel_q        <= action;
						slot_found_q <= 1'b0;
						found_q      <= 1'b0;
						state_q      <= action ? S_REL : S_SCAN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q < PIECE_CNT && !pe[0].valid && !slot_found_q) begin
						slot_found_q <= 1'b1;
					end
					if (cnt_q == SCAN_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_REL: begin
					cnt_q <= cnt_q + 1'b1;
					if (head_hit) begin
						found_q <= 1'b1;
					end
					if (cnt_q == PIECE_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (done_fire) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload, owner sum and result registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			owner_q <= owner_id[OWNER_BITS-1:0];
			size_q  <= request_size;
			sum_q   <= '0;
		end
		if (state_q == S_SCAN && cnt_q < PIECE_CNT) begin
			if (pe[0].valid && pe[0].owner == owner_q) begin
				sum_q <= sum_q + pe[0].len;
			end
			if (!pe[0].valid && !slot_found_q) begin
				slot_q <= cnt_q[PIDX_W-1:0];
			end
		end
		if (done_fire) begin
			if (rel_q) begin
				status_q <= found_q ? ST_DONE : ST_UNKNOWN;
				addr_q   <= '0;
				total_q  <= '0;
			end else if (!pick_ok) begin
				status_q <= ST_NOFIT;
				addr_q   <= '0;
				total_q  <= sum_q;
			end else if (!slot_found_q) begin
				status_q <= ST_FULL;
				addr_q   <= '0;
				total_q  <= sum_q;
			end else begin
				status_q <= ST_DONE;
				addr_q   <= tokf.start;
				total_q  <= sum_q + size_q;
			end
		end
	end

endmodule
